// ===== hw/rtl/crf_pkg.sv =====
// Shared constants, tables and types for the complementary roll filter.
package crf_pkg;

   // CORDIC atan2 sizing.
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int STEP_W       = 5;
   localparam int CW           = 35;
   localparam int AW           = 26;

   // Rotation divider sizing: 48-bit dividend, two quotient bits per cycle.
   localparam int DIV_N_W    = 48;
   localparam int DIV_R_W    = 17;
   localparam int DIV_CYCLES = 24;
   localparam int DIV_CNT_W  = 5;
   localparam int MAG_W      = 31;
   localparam int QW         = 34;

   // Shared multiplier sizing.
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = 53;

   // Angle constants in Q16.16 degrees.
   localparam logic signed [AW-1:0] HALF_TURN    = 26'sd11796480;
   localparam logic signed [AW-1:0] QUARTER_TURN = 26'sd5898240;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_RANGE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 2'd1;
   localparam logic [15:0] BLEND_WEIGHT_RESET = 16'd64225;

   // atan(2^-i) in Q16.16 degrees, rounded to nearest.
   localparam logic [22:0] ATAN_TABLE [ATAN_LEN] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
      23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
      23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
      23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
   };

   // Gyro sensitivity times 1000 ms, and half of it for rounding.
   localparam logic [DIV_R_W-1:0] DIVISOR [4] = '{
      17'd131000, 17'd65500, 17'd32800, 17'd16400
   };
   localparam logic [15:0] DIVISOR_HALF [4] = '{
      16'd65500, 16'd32750, 16'd16400, 16'd8200
   };

   // Sequencer states of the top level.
   typedef enum logic [7:0] {
      ST_IDLE      = 8'b00000001,
      ST_RATE_MUL  = 8'b00000010,
      ST_DIV_START = 8'b00000100,
      ST_WAIT      = 8'b00001000,
      ST_BLEND_A   = 8'b00010000,
      ST_BLEND_B   = 8'b00100000,
      ST_BLEND_C   = 8'b01000000,
      ST_FINISH    = 8'b10000000
   } state_type;

endpackage

// ===== hw/rtl/complementary_filter_roll_unit.sv =====
// Top level of the complementary roll filter: sequencer, shared multiplier, state.
//
// Requests carry one IMU sample (accel Y, accel Z, gyro X, elapsed ms) on the
// req_ channel; each request produces exactly one response on the rsp_ channel
// with the filtered roll and the accelerometer-only roll, both in 1/256 degree.
// A request is taken when req_valid is high and req_stall is low; a response is
// taken when rsp_valid is high and rsp_stall is low.
// A new request is taken in the cycle after the response is loaded. The rotation
// divider, which produces two quotient bits per cycle, sets the pace; the
// 16-step CORDIC runs alongside it, and the rate product and the two blend
// products share one 35x18 multiplier, one per cycle.
// The response sits in an output register: while it waits, the next request is
// already accepted and computed, and only the loading of its response waits for
// the slot to be taken.
// csr_ writes set gyro_range (index 0) and blend_weight (index 1); csr_ready is
// always high and other indexes are ignored. Write only while idle.
// Reset (synchronous) clears the filtered angle to zero degrees, sets the gyro
// range to 250 dps and the blend weight to 64225, and drops rsp_valid.
module complementary_filter_roll_unit (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_accel_y,
   input  logic signed [15:0]  req_accel_z,
   input  logic signed [15:0]  req_gyro_x,
   input  logic [15:0]         req_elapsed_ms,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [23:0]  rsp_roll_angle,
   output logic signed [16:0]  rsp_accel_roll,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);

   crf_pkg::state_type                       state_ff, state_in;

   logic [1:0]                               gyro_range_ff;
   logic [15:0]                              blend_weight_ff;

   logic signed [15:0]                       gyro_ff;
   logic [15:0]                              ms_ff;
   logic signed [crf_pkg::PROD_W-1:0]        prod_ff;
   logic                                     neg_ff;
   logic signed [crf_pkg::QW-1:0]            rot_ff;
   logic signed [crf_pkg::AW-1:0]            accel_ff;
   logic signed [crf_pkg::PROD_W-1:0]        sum_ff;
   logic signed [31:0]                       angle_ff;

   logic                                     rsp_valid_ff;
   logic signed [23:0]                       rsp_roll_ff;
   logic signed [16:0]                       rsp_accel_ff;

   logic                                     req_take;
   logic                                     rsp_free;
   logic                                     finish_go;

   logic signed [crf_pkg::MUL_A_W-1:0]       mul_a;
   logic signed [crf_pkg::MUL_B_W-1:0]       mul_b;
   logic signed [crf_pkg::PROD_W-1:0]        mul_p;

   logic signed [31:0]                       prod_lo;
   logic signed [31:0]                       prod_mag;
   logic                                     div_start;
   logic                                     div_busy;
   logic [crf_pkg::QW-1:0]                   div_quot;
   logic                                     cor_busy;
   logic signed [crf_pkg::AW-1:0]            cor_angle;

   logic signed [36:0]                       nv_wide;
   logic signed [31:0]                       nv_sat;
   logic signed [32:0]                       ro_sum;
   logic signed [24:0]                       ro_wide;
   logic signed [23:0]                       ro_sat;
   logic signed [crf_pkg::AW:0]              ar_sum;
   logic signed [18:0]                       ar_wide;
   logic signed [16:0]                       ar_sat;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != crf_pkg::ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign finish_go = (state_ff == crf_pkg::ST_FINISH) && rsp_free;
   assign csr_ready = 1'b1;

   // Accelerometer angle, started as soon as the request is taken.
   crf_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (req_take),
      .accel_y (req_accel_y),
      .accel_z (req_accel_z),
      .busy    (cor_busy),
      .angle   (cor_angle)
   );

   // Magnitude of gyro_x * elapsed_ms for the rotation divider.
   always_comb begin
      prod_lo  = prod_ff[31:0];
      prod_mag = prod_lo[31] ? (32'sd0 - prod_lo) : prod_lo;
   end

   assign div_start = (state_ff == crf_pkg::ST_DIV_START);

   crf_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .magnitude  (prod_mag[crf_pkg::MAG_W-1:0]),
      .gyro_range (gyro_range_ff),
      .busy       (div_busy),
      .quotient   (div_quot)
   );

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         crf_pkg::ST_RATE_MUL: begin
            mul_a = {{(crf_pkg::MUL_A_W - 16){gyro_ff[15]}}, gyro_ff};
            mul_b = {2'b00, ms_ff};
         end
         crf_pkg::ST_BLEND_A: begin
            mul_a = {{3{angle_ff[31]}}, angle_ff} + {rot_ff[crf_pkg::QW-1], rot_ff};
            mul_b = {2'b00, blend_weight_ff};
         end
         crf_pkg::ST_BLEND_B: begin
            mul_a = {{(crf_pkg::MUL_A_W - crf_pkg::AW){accel_ff[crf_pkg::AW-1]}}, accel_ff};
            mul_b = 18'sd65536 - {2'b00, blend_weight_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Round the blended sum into the state, then into the response fields.
   always_comb begin
      nv_wide = sum_ff[crf_pkg::PROD_W-1:16];
      if (!nv_wide[36] && (nv_wide[35:31] != 5'b00000)) begin
         nv_sat = 32'sh7FFFFFFF;
      end else if (nv_wide[36] && (nv_wide[35:31] != 5'b11111)) begin
         nv_sat = 32'sh80000000;
      end else begin
         nv_sat = nv_wide[31:0];
      end

      ro_sum  = {nv_sat[31], nv_sat} + 33'sd128;
      ro_wide = ro_sum[32:8];
      if (!ro_wide[24] && ro_wide[23]) begin
         ro_sat = 24'sh7FFFFF;
      end else if (ro_wide[24] && !ro_wide[23]) begin
         ro_sat = 24'sh800000;
      end else begin
         ro_sat = ro_wide[23:0];
      end

      ar_sum  = {accel_ff[crf_pkg::AW-1], accel_ff} + 27'sd128;
      ar_wide = ar_sum[crf_pkg::AW:8];
      if (ar_wide > 19'sd46080) begin
         ar_sat = 17'sd46080;
      end else if (ar_wide < -19'sd46080) begin
         ar_sat = -17'sd46080;
      end else begin
         ar_sat = ar_wide[16:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         crf_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = crf_pkg::ST_RATE_MUL;
            end
         end
         crf_pkg::ST_RATE_MUL:  state_in = crf_pkg::ST_DIV_START;
         crf_pkg::ST_DIV_START: state_in = crf_pkg::ST_WAIT;
         crf_pkg::ST_WAIT: begin
            if (!div_busy && !cor_busy) begin
               state_in = crf_pkg::ST_BLEND_A;
            end
         end
         crf_pkg::ST_BLEND_A: state_in = crf_pkg::ST_BLEND_B;
         crf_pkg::ST_BLEND_B: state_in = crf_pkg::ST_BLEND_C;
         crf_pkg::ST_BLEND_C: state_in = crf_pkg::ST_FINISH;
         crf_pkg::ST_FINISH: begin
            if (rsp_free) begin
               state_in = crf_pkg::ST_IDLE;
            end
         end
         default: state_in = crf_pkg::ST_IDLE;
      endcase
   end

   // Control state, configuration registers and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= crf_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         gyro_range_ff   <= 2'd0;
         blend_weight_ff <= crf_pkg::BLEND_WEIGHT_RESET;
         angle_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
            angle_ff     <= nv_sat;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               crf_pkg::CSR_GYRO_RANGE:   gyro_range_ff   <= csr_data[1:0];
               crf_pkg::CSR_BLEND_WEIGHT: blend_weight_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         gyro_ff <= req_gyro_x;
         ms_ff   <= req_elapsed_ms;
      end
      if ((state_ff == crf_pkg::ST_RATE_MUL) || (state_ff == crf_pkg::ST_BLEND_A) ||
          (state_ff == crf_pkg::ST_BLEND_B)) begin
         prod_ff <= mul_p;
      end
      if (state_ff == crf_pkg::ST_DIV_START) begin
         neg_ff <= prod_lo[31];
      end
      if ((state_ff == crf_pkg::ST_WAIT) && !div_busy && !cor_busy) begin
         rot_ff   <= neg_ff ? (crf_pkg::QW'(0) - div_quot) : div_quot;
         accel_ff <= cor_angle;
      end
      if (state_ff == crf_pkg::ST_BLEND_B) begin
         sum_ff <= prod_ff;
      end
      if (state_ff == crf_pkg::ST_BLEND_C) begin
         sum_ff <= sum_ff + prod_ff + 53'sd32768;
      end
      if (finish_go) begin
         rsp_roll_ff  <= ro_sat;
         rsp_accel_ff <= ar_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_roll_angle = rsp_roll_ff;
   assign rsp_accel_roll = rsp_accel_ff;

endmodule

// ===== hw/rtl/crf_cordic.sv =====
// Iterative vectoring CORDIC that gives atan2(y, z) in Q16.16 degrees.
module crf_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [15:0]               accel_y,
   input  logic signed [15:0]               accel_z,
   output logic                             busy,
   output logic signed [crf_pkg::AW-1:0]    angle
);

   logic                             busy_ff, busy_in;
   logic [crf_pkg::STEP_W-1:0]       step_ff, step_in;
   logic signed [crf_pkg::CW-1:0]    x_ff, x_in;
   logic signed [crf_pkg::CW-1:0]    y_ff, y_in;
   logic signed [crf_pkg::AW-1:0]    acc_ff, acc_in;
   logic                             special_ff, special_in;

   logic signed [16:0]               x0, y0;
   logic signed [crf_pkg::AW-1:0]    acc0;
   logic                             special0;
   logic signed [crf_pkg::CW-1:0]    dx, dy;
   logic signed [crf_pkg::AW-1:0]    atan_val;
   logic                             last_step;

   // Pre-rotation into the right half plane, plus the axis special cases.
   always_comb begin
      special0 = (accel_y == 16'sd0) && (accel_z[15] || (accel_z == 16'sd0));
      if (accel_z[15]) begin
         if (!accel_y[15]) begin
            x0   = {accel_y[15], accel_y};
            y0   = 17'sd0 - {accel_z[15], accel_z};
            acc0 = crf_pkg::QUARTER_TURN;
         end else begin
            x0   = 17'sd0 - {accel_y[15], accel_y};
            y0   = {accel_z[15], accel_z};
            acc0 = -crf_pkg::QUARTER_TURN;
         end
      end else begin
         x0   = {accel_z[15], accel_z};
         y0   = {accel_y[15], accel_y};
         acc0 = '0;
      end
      if (special0) begin
         acc0 = (accel_z == 16'sd0) ? '0 : crf_pkg::HALF_TURN;
      end
   end

   // One micro-rotation per cycle.
   always_comb begin
      dx        = y_ff >>> step_ff;
      dy        = x_ff >>> step_ff;
      atan_val  = {3'b000, crf_pkg::ATAN_TABLE[step_ff]};
      last_step = (step_ff == crf_pkg::STEP_W'(crf_pkg::CORDIC_STEPS - 1));
   end

   // Next-state logic for the iteration.
   always_comb begin
      busy_in    = busy_ff;
      step_in    = step_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      acc_in     = acc_ff;
      special_in = special_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         x_in       = {{2{x0[16]}}, x0, 16'b0};
         y_in       = {{2{y0[16]}}, y0, 16'b0};
         acc_in     = acc0;
         special_in = special0;
      end else if (busy_ff) begin
         if (!y_ff[crf_pkg::CW-1] && (y_ff != '0)) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            if (!special_ff) begin
               acc_in = acc_ff + atan_val;
            end
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            if (!special_ff) begin
               acc_in = acc_ff - atan_val;
            end
         end
         if (last_step) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      acc_ff     <= acc_in;
      special_ff <= special_in;
   end

   // Clamp the accumulated angle to a half turn either way.
   always_comb begin
      if (acc_ff > crf_pkg::HALF_TURN) begin
         angle = crf_pkg::HALF_TURN;
      end else if (acc_ff < -crf_pkg::HALF_TURN) begin
         angle = -crf_pkg::HALF_TURN;
      end else begin
         angle = acc_ff;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== hw/rtl/crf_divider.sv =====
// Restoring divider, two quotient bits per cycle, for the gyro rotation.
module crf_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [crf_pkg::MAG_W-1:0]     magnitude,
   input  logic [1:0]                    gyro_range,
   output logic                          busy,
   output logic [crf_pkg::QW-1:0]        quotient
);

   logic                              busy_ff, busy_in;
   logic [crf_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [crf_pkg::DIV_N_W-1:0]       n_ff, n_in;
   logic [crf_pkg::DIV_R_W-1:0]       r_ff, r_in;
   logic [crf_pkg::DIV_R_W-1:0]       d_ff, d_in;

   logic [crf_pkg::DIV_R_W:0]         t1, t2, d_ext;
   logic [crf_pkg::DIV_R_W-1:0]       r1, r2;
   logic                              ge1, ge2;

   // Two compare-and-subtract steps; the dividend shifts out as quotient shifts in.
   always_comb begin
      d_ext = {1'b0, d_ff};
      t1    = {r_ff, n_ff[crf_pkg::DIV_N_W-1]};
      ge1   = (t1 >= d_ext);
      r1    = ge1 ? crf_pkg::DIV_R_W'(t1 - d_ext) : t1[crf_pkg::DIV_R_W-1:0];
      t2    = {r1, n_ff[crf_pkg::DIV_N_W-2]};
      ge2   = (t2 >= d_ext);
      r2    = ge2 ? crf_pkg::DIV_R_W'(t2 - d_ext) : t2[crf_pkg::DIV_R_W-1:0];
   end

   // The rounding half of the divisor fills the low bits of the shifted dividend.
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      n_in    = n_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         n_in    = {1'b0, magnitude, crf_pkg::DIVISOR_HALF[gyro_range]};
         r_in    = '0;
         d_in    = crf_pkg::DIVISOR[gyro_range];
      end else if (busy_ff) begin
         n_in = {n_ff[crf_pkg::DIV_N_W-3:0], ge1, ge2};
         r_in = r2;
         if (cnt_ff == crf_pkg::DIV_CNT_W'(crf_pkg::DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      n_ff   <= n_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
   end

   assign busy     = busy_ff;
   assign quotient = n_ff[crf_pkg::QW-1:0];

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the complementary roll filter with random stimulus and stalls.
module testbench;

   // Spare register indexes that the block must ignore.
   localparam logic [crf_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [crf_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // Angle constants and state bounds in Q16.16 degrees; roll bounds in 1/256 degree.
   localparam longint HALF_TURN_DEG = 64'sd11796480;
   localparam longint QUARTER_DEG   = 64'sd5898240;
   localparam longint STATE_MAX     = 64'sh7FFF_FFFF;
   localparam longint STATE_MIN     = -64'sh8000_0000;
   localparam longint ROLL_MAX      = 64'sd8388607;
   localparam longint ROLL_MIN      = -64'sd8388608;
   localparam longint ACCEL_LIMIT   = 64'sd46080;
   localparam int     ITER_COUNT    = 16;
   localparam int     DRAIN_CYCLES  = 40;
   localparam int     PHASE_ITEMS   = 235;

   typedef struct packed {
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic [15:0]        elapsed_ms;
   } sample_type;

   typedef struct packed {
      logic signed [23:0] roll;
      logic signed [16:0] accel;
   } roll_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic signed [15:0] req_gyro_x = '0;
   logic [15:0]        req_elapsed_ms = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_roll_angle;
   logic signed [16:0] rsp_accel_roll;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   // Predictor state and configuration copies.
   int          angle_q16;
   logic [1:0]  gyro_sel;
   logic [15:0] alpha_q16;

   sample_type sample_q[$];
   roll_type   roll_expect_q[$];
   bit      req_fire = 1'b0;
   bit      csr_done = 1'b0;
   bit      idle_on = 1'b1;
   int      req_gap = 0;
   int      stall_left = 0;
   int      mismatch_count = 0;

   longint atan_deg_q16 [ITER_COUNT] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   complementary_filter_roll_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .req_gyro_x     (req_gyro_x),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_roll_angle (rsp_roll_angle),
      .rsp_accel_roll (rsp_accel_roll),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog for a hung run.
   initial begin
      #7200000;
      $display("testbench failed");
      $finish;
   end

   // Gyro sensitivity times 1000 ms for each full-scale range.
   function automatic longint rate_divisor(logic [1:0] sel);
      case (sel)
         2'd0: return 131000;
         2'd1: return 65500;
         2'd2: return 32800;
         default: return 16400;
      endcase
   endfunction

   // Integer division rounded to nearest, ties away from zero.
   function automatic longint round_div(longint n, longint d);
      longint m;
      longint q;
      m = (n < 0) ? -n : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -q : q;
   endfunction

   // Vectoring CORDIC: atan2(y, z) in Q16.16 degrees.
   function automatic longint cordic_roll(longint y, longint z);
      longint x;
      longint yy;
      longint acc;
      longint dx;
      longint dy;
      longint t;
      int     i;
      if (y == 0 && z == 0) return 0;
      if (y == 0 && z < 0) return HALF_TURN_DEG;
      x = z;
      yy = y;
      acc = 0;
      // Fold the left half plane into the right one first.
      if (x < 0) begin
         t = x;
         if (yy >= 0) begin
            x = yy;
            yy = -t;
            acc = QUARTER_DEG;
         end else begin
            x = -yy;
            yy = t;
            acc = -QUARTER_DEG;
         end
      end
      x = x * 65536;
      yy = yy * 65536;
      for (i = 0; i < ITER_COUNT; i++) begin
         dx = yy >>> i;
         dy = x >>> i;
         if (yy > 0) begin
            x = x + dx;
            yy = yy - dy;
            acc = acc + atan_deg_q16[i];
         end else begin
            x = x - dx;
            yy = yy + dy;
            acc = acc - atan_deg_q16[i];
         end
      end
      if (acc > HALF_TURN_DEG) acc = HALF_TURN_DEG;
      if (acc < -HALF_TURN_DEG) acc = -HALF_TURN_DEG;
      return acc;
   endfunction

   // Advance the filtered angle by one sample and return both roll outputs.
   function automatic roll_type predict_roll(sample_type s);
      longint   rot;
      longint   acc;
      longint   alpha;
      longint   sum;
      longint   nv;
      longint   ro;
      longint   ar;
      roll_type r;
      rot = round_div(longint'(s.gyro_x) * longint'(s.elapsed_ms) * 65536,
                      rate_divisor(gyro_sel));
      acc = cordic_roll(longint'(s.accel_y), longint'(s.accel_z));
      alpha = longint'(alpha_q16);
      sum = alpha * (longint'(angle_q16) + rot) + (65536 - alpha) * acc;
      nv = (sum + 32768) >>> 16;
      if (nv > STATE_MAX) nv = STATE_MAX;
      if (nv < STATE_MIN) nv = STATE_MIN;
      angle_q16 = int'(nv[31:0]);
      ro = (nv + 128) >>> 8;
      if (ro > ROLL_MAX) ro = ROLL_MAX;
      if (ro < ROLL_MIN) ro = ROLL_MIN;
      ar = (acc + 128) >>> 8;
      if (ar > ACCEL_LIMIT) ar = ACCEL_LIMIT;
      if (ar < -ACCEL_LIMIT) ar = -ACCEL_LIMIT;
      r.roll = ro[23:0];
      r.accel = ar[16:0];
      return r;
   endfunction

   // Count a failure and report the first few.
   function automatic void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   // Track register writes in the predictor's configuration.
   always @(posedge clock) begin
      if (reset) begin
         gyro_sel <= 2'd0;
         alpha_q16 <= crf_pkg::BLEND_WEIGHT_RESET;
         csr_done <= 1'b0;
      end else begin
         csr_done <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               crf_pkg::CSR_GYRO_RANGE: gyro_sel <= csr_data[1:0];
               crf_pkg::CSR_BLEND_WEIGHT: alpha_q16 <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // Predict the response of every accepted request.
   always @(posedge clock) begin : take_sample
      sample_type s;
      if (reset) begin
         angle_q16 = 0;
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            s.accel_y = req_accel_y;
            s.accel_z = req_accel_z;
            s.gyro_x = req_gyro_x;
            s.elapsed_ms = req_elapsed_ms;
            roll_expect_q.push_back(predict_roll(s));
         end
      end
   end

   // Request driver: presents queued samples with random gaps between them.
   always @(negedge clock) begin : drive_samples
      sample_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            nxt = sample_q.pop_front();
            req_accel_y <= nxt.accel_y;
            req_accel_z <= nxt.accel_z;
            req_gyro_x <= nxt.gyro_x;
            req_elapsed_ms <= nxt.elapsed_ms;
            req_valid <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) req_gap = $urandom_range(1, 4);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall generator in random bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Response monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : check_roll
      roll_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (roll_expect_q.size() == 0) begin
            note_failure($sformatf("unexpected response: roll %0d accel %0d",
                                   rsp_roll_angle, rsp_accel_roll));
         end else begin
            want = roll_expect_q.pop_front();
            if (rsp_roll_angle !== want.roll || rsp_accel_roll !== want.accel)
               note_failure($sformatf(
                  "mismatch: expected roll %0d accel %0d, got roll %0d accel %0d",
                  want.roll, want.accel, rsp_roll_angle, rsp_accel_roll));
         end
      end
   end

   task automatic queue_sample(int y, int z, int g, int ms);
      sample_type s;
      s.accel_y = 16'(y);
      s.accel_z = 16'(z);
      s.gyro_x = 16'(g);
      s.elapsed_ms = 16'(ms);
      sample_q.push_back(s);
   endtask

   // Wait until every queued request has been answered.
   task automatic wait_idle();
      while (sample_q.size() != 0 || req_valid || roll_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(negedge clock); while (!csr_done);
      csr_valid = 1'b0;
   endtask

   // Stimulus sequence.
   initial begin : stimulus
      sample_type  s;
      int          ph;
      int          n;
      logic [15:0] weight;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed samples at reset configuration: quadrants, axes, special cases.
      queue_sample(0, 0, 0, 0);
      queue_sample(0, -1000, 0, 10);
      queue_sample(0, -32768, 100, 5);
      queue_sample(32767, 0, 0, 1);
      queue_sample(-32768, 0, 0, 1);
      queue_sample(0, 32767, 0, 1);
      queue_sample(-32768, -32768, -1, 1);
      queue_sample(32767, -32768, 1, 1);
      queue_sample(1, -32768, 0, 2);
      queue_sample(-1, -32768, 0, 2);
      queue_sample(-1, -1, 0, 2);
      queue_sample(16384, 16384, 32767, 65535);
      // Fast negative rotation drives the state into saturation.
      repeat (3) queue_sample(0, 16384, -32768, 65535);
      queue_sample(0, 16384, 32767, 65535);
      wait_idle();

      // Widest range, gyro path only: saturate high.
      write_reg(crf_pkg::CSR_GYRO_RANGE, 16'hFFFF);
      write_reg(crf_pkg::CSR_BLEND_WEIGHT, 16'hFFFF);
      repeat (3) queue_sample(0, 16384, 32767, 65535);
      queue_sample(100, 200, -32768, 0);
      wait_idle();

      // Accelerometer only; spare indexes must not disturb the setup.
      write_reg(crf_pkg::CSR_GYRO_RANGE, 16'd1);
      write_reg(crf_pkg::CSR_BLEND_WEIGHT, 16'd0);
      write_reg(CSR_SPARE_2, 16'hFFFF);
      write_reg(CSR_SPARE_3, 16'h5A5A);
      queue_sample(12345, -23456, 32767, 65535);
      queue_sample(0, 0, -32768, 65535);
      wait_idle();

      // Random phases, each with its own configuration.
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: weight = 16'hFFFF;
            1: weight = 16'd0;
            2: weight = crf_pkg::BLEND_WEIGHT_RESET;
            3: weight = 16'd1;
            4: weight = 16'd32768;
            default: weight = 16'($urandom);
         endcase
         idle_on = (ph % 3 != 2) && (ph != 7);
         write_reg(crf_pkg::CSR_GYRO_RANGE, {14'($urandom), 2'(ph % 4)});
         write_reg(crf_pkg::CSR_BLEND_WEIGHT, weight);
         if ($urandom_range(0, 1) == 0)
            write_reg((ph % 2 == 0) ? CSR_SPARE_2 : CSR_SPARE_3, 16'($urandom));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Accel: full range mostly, with axis and near-origin cases mixed in.
            case ($urandom_range(0, 7))
               0: begin s.accel_y = 16'sd0; s.accel_z = 16'($urandom); end
               1: begin s.accel_y = 16'($urandom); s.accel_z = 16'sd0; end
               2: begin
                  s.accel_y = 16'($urandom_range(0, 6) - 3);
                  s.accel_z = 16'($urandom_range(0, 6) - 3);
               end
               default: begin s.accel_y = 16'($urandom); s.accel_z = 16'($urandom); end
            endcase
            // Gyro: moderate rates usually, full scale at times.
            if ($urandom_range(0, 9) < 6) s.gyro_x = 16'($urandom_range(0, 4000) - 2000);
            else s.gyro_x = 16'($urandom);
            // Interval: short typical sample periods, some long ones.
            case ($urandom_range(0, 9))
               6, 7: s.elapsed_ms = 16'($urandom_range(0, 1000));
               8, 9: s.elapsed_ms = 16'($urandom);
               default: s.elapsed_ms = 16'($urandom_range(0, 20));
            endcase
            sample_q.push_back(s);
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/crf_pkg.sv
hw/rtl/crf_cordic.sv
hw/rtl/crf_divider.sv
hw/rtl/complementary_filter_roll_unit.sv
tb/testbench.sv
